// File: design/pmsc_pkg.sv
// Package for the preset move and settle controller.
// Holds field widths, beat layouts, register indexes and the item, phase,
// direction and action codes. It depends on nothing else.
package pmsc_pkg;

	localparam int HEIGHT_BITS     = 12;
	localparam int CORRECTION_BITS = 4;
	localparam int SIGNED_BITS     = HEIGHT_BITS + 1;
	localparam int EXT_BITS        = HEIGHT_BITS + 3;

	localparam int GOAL_LSB   = 0;
	localparam int DIR_LSB    = GOAL_LSB + HEIGHT_BITS;
	localparam int TAG_LSB    = DIR_LSB + 2;
	localparam int TIME_LSB   = TAG_LSB + 32;
	localparam int LIVE_LSB   = TIME_LSB + 32;
	localparam int STEADY_LSB = LIVE_LSB + SIGNED_BITS;
	localparam int IN_FIELD_BITS = STEADY_LSB + SIGNED_BITS;
	localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

	localparam int OUT_FIELD_BITS = 7;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_MARGIN      = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SETTLE_TOLERANCE = 4'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SETTLE_TIME      = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CORRECTIONS  = 4'd3;

	localparam logic [7:0]  STOP_MARGIN_RESET      = 8'd10;
	localparam logic [7:0]  SETTLE_TOLERANCE_RESET = 8'd5;
	localparam logic [15:0] SETTLE_TIME_RESET      = 16'd500;
	localparam logic [3:0]  MAX_CORRECTIONS_RESET  = 4'd2;

	typedef enum logic [1:0] {
		FUNC_ABORT  = 2'd0,
		FUNC_START  = 2'd1,
		FUNC_SAMPLE = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_MOVING   = 2'd1,
		PH_SETTLING = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_SETTLE   = 3'd1,
		ACT_COMPLETE = 3'd2,
		ACT_LIMIT    = 3'd3,
		ACT_UP       = 3'd4,
		ACT_DOWN     = 3'd5
	} action_t;

endpackage

// File: design/preset_move_settle_controller_unit.sv
// Top level of the preset move and settle controller.
// Holds the input register, the phase logic and the result register.
// Depends on pmsc_pkg.

// Every input beat yields exactly one result beat, which passes through the input
// register and then the result register. The block takes one beat per
// cycle; the only limit is the result register, which holds its beat while
// m_axis_tready is low and lets the input register fill behind it.
// Configuration writes are taken in any cycle and should be made only while no
// beat is in flight.
module preset_move_settle_controller_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// goal_height, start_dir, sample_tag, time_now, live_height, steady_height
	input  logic [pmsc_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
	// func
	input  logic [1:0]                             s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// action, phase_now, dir_now
	output logic [pmsc_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pmsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [pmsc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int HB = pmsc_pkg::HEIGHT_BITS;
	localparam int SB = pmsc_pkg::SIGNED_BITS;
	localparam int EB = pmsc_pkg::EXT_BITS;
	localparam int CB = pmsc_pkg::CORRECTION_BITS;

	logic [7:0]  stop_margin_q;
	logic [7:0]  settle_tolerance_q;
	logic [15:0] settle_time_q;
	logic [3:0]  max_corrections_q;

	pmsc_pkg::phase_t phase_q, phase_d;
	pmsc_pkg::dir_t   dir_q, dir_d;
	logic [SB-1:0]    target_q, target_d;
	logic [31:0]      last_tag_q, last_tag_d;
	logic [31:0]      settle_start_q, settle_start_d;
	logic [CB-1:0]    count_q, count_d;

	logic             valid_s1;
	logic [1:0]       func_s1;
	logic [HB-1:0]    goal_s1;
	logic [1:0]       sdir_s1;
	logic [31:0]      tag_s1;
	logic [31:0]      time_s1;
	logic [SB-1:0]    live_s1;
	logic [SB-1:0]    steady_s1;

	logic             m_valid_q;
	logic [pmsc_pkg::OUT_DATA_BITS-1:0] m_data_q;

	logic advance;
	logic take_in;

	logic signed [EB-1:0] live_x, steady_x, target_x, margin_x, err_x, mag_x, tol_x;
	logic        sample_ok, boundary, wait_done, in_tol, at_limit;
	logic [31:0] elapsed;
	pmsc_pkg::action_t action_d;
	pmsc_pkg::dir_t    start_dir_v;

	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_margin_q      <= pmsc_pkg::STOP_MARGIN_RESET;
			settle_tolerance_q <= pmsc_pkg::SETTLE_TOLERANCE_RESET;
			settle_time_q      <= pmsc_pkg::SETTLE_TIME_RESET;
			max_corrections_q  <= pmsc_pkg::MAX_CORRECTIONS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pmsc_pkg::REG_STOP_MARGIN:      stop_margin_q      <= cfg_data[7:0];
				pmsc_pkg::REG_SETTLE_TOLERANCE: settle_tolerance_q <= cfg_data[7:0];
				pmsc_pkg::REG_SETTLE_TIME:      settle_time_q      <= cfg_data[15:0];
				pmsc_pkg::REG_MAX_CORRECTIONS:  max_corrections_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1   <= s_axis_tuser;
			goal_s1   <= s_axis_tdata[pmsc_pkg::GOAL_LSB +: HB];
			sdir_s1   <= s_axis_tdata[pmsc_pkg::DIR_LSB +: 2];
			tag_s1    <= s_axis_tdata[pmsc_pkg::TAG_LSB +: 32];
			time_s1   <= s_axis_tdata[pmsc_pkg::TIME_LSB +: 32];
			live_s1   <= s_axis_tdata[pmsc_pkg::LIVE_LSB +: SB];
			steady_s1 <= s_axis_tdata[pmsc_pkg::STEADY_LSB +: SB];
		end
	end

	always_comb begin
		live_x    = $signed({{(EB-SB){live_s1[SB-1]}}, live_s1});
		steady_x  = $signed({{(EB-SB){steady_s1[SB-1]}}, steady_s1});
		target_x  = $signed({{(EB-SB){target_q[SB-1]}}, target_q});
		margin_x  = $signed({{(EB-8){1'b0}}, stop_margin_q});
		tol_x     = $signed({{(EB-8){1'b0}}, settle_tolerance_q});
		sample_ok = (phase_q != pmsc_pkg::PH_IDLE) && !live_s1[SB-1] && !steady_s1[SB-1]
			&& (tag_s1 != last_tag_q);
		case (dir_q)
			pmsc_pkg::DIR_UP:   boundary = live_x >= (target_x - margin_x);
			pmsc_pkg::DIR_DOWN: boundary = live_x <= (target_x + margin_x);
			default:            boundary = 1'b1;
		endcase
		elapsed   = time_s1 - settle_start_q;
		wait_done = elapsed >= {16'd0, settle_time_q};
		err_x     = steady_x - target_x;
		mag_x     = err_x[EB-1] ? -err_x : err_x;
		in_tol    = mag_x <= tol_x;
		at_limit  = count_q >= max_corrections_q;
		start_dir_v = (sdir_s1 == 2'd3) ? pmsc_pkg::DIR_STOP : pmsc_pkg::dir_t'(sdir_s1);
	end

	always_comb begin
		phase_d        = phase_q;
		dir_d          = dir_q;
		target_d       = target_q;
		last_tag_d     = last_tag_q;
		settle_start_d = settle_start_q;
		count_d        = count_q;
		case (func_s1)
			pmsc_pkg::FUNC_ABORT, pmsc_pkg::FUNC_START: begin
				phase_d        = pmsc_pkg::PH_IDLE;
				dir_d          = pmsc_pkg::DIR_STOP;
				target_d       = '1;
				last_tag_d     = '0;
				settle_start_d = '0;
				count_d        = '0;
				if (func_s1 == pmsc_pkg::FUNC_START) begin
					phase_d    = pmsc_pkg::PH_MOVING;
					dir_d      = start_dir_v;
					target_d   = {1'b0, goal_s1};
					last_tag_d = tag_s1;
				end
			end
			pmsc_pkg::FUNC_SAMPLE: begin
				if (sample_ok) begin
					last_tag_d = tag_s1;
					if (phase_q == pmsc_pkg::PH_MOVING) begin
						if (boundary) begin
							phase_d        = pmsc_pkg::PH_SETTLING;
							dir_d          = pmsc_pkg::DIR_STOP;
							settle_start_d = time_s1;
						end
					end else if (wait_done) begin
						if (in_tol || at_limit) begin
							phase_d        = pmsc_pkg::PH_IDLE;
							dir_d          = pmsc_pkg::DIR_STOP;
							target_d       = '1;
							last_tag_d     = '0;
							settle_start_d = '0;
							count_d        = '0;
						end else begin
							count_d = count_q + 1'b1;
							phase_d = pmsc_pkg::PH_MOVING;
							dir_d   = err_x[EB-1] ? pmsc_pkg::DIR_UP : pmsc_pkg::DIR_DOWN;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		action_d = pmsc_pkg::ACT_NONE;
		if (func_s1 == pmsc_pkg::FUNC_SAMPLE && sample_ok) begin
			if (phase_q == pmsc_pkg::PH_MOVING) begin
				if (boundary) begin
					action_d = pmsc_pkg::ACT_SETTLE;
				end
			end else if (wait_done) begin
				if (in_tol) begin
					action_d = pmsc_pkg::ACT_COMPLETE;
				end else if (at_limit) begin
					action_d = pmsc_pkg::ACT_LIMIT;
				end else begin
					action_d = err_x[EB-1] ? pmsc_pkg::ACT_UP : pmsc_pkg::ACT_DOWN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= pmsc_pkg::PH_IDLE;
			dir_q          <= pmsc_pkg::DIR_STOP;
			target_q       <= '1;
			last_tag_q     <= '0;
			settle_start_q <= '0;
			count_q        <= '0;
		end else if (advance) begin
			phase_q        <= phase_d;
			dir_q          <= dir_d;
			target_q       <= target_d;
			last_tag_q     <= last_tag_d;
			settle_start_q <= settle_start_d;
			count_q        <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {{(pmsc_pkg::OUT_DATA_BITS-pmsc_pkg::OUT_FIELD_BITS){1'b0}},
				dir_d, phase_d, action_d};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == pmsc_pkg::PH_IDLE) |-> (target_q == '1 && count_q == '0
			&& dir_q == pmsc_pkg::DIR_STOP))
		else $error("idle phase with leftover target, count or direction");

	a_settle_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == pmsc_pkg::PH_SETTLING) |-> (dir_q == pmsc_pkg::DIR_STOP))
		else $error("settling while the actuator is commanded to move");

	a_settle_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && action_d == pmsc_pkg::ACT_SETTLE) |=>
		(phase_q == pmsc_pkg::PH_SETTLING && settle_start_q == $past(time_s1)))
		else $error("settle action did not enter settling with its start time");

	a_move_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (action_d == pmsc_pkg::ACT_UP || action_d == pmsc_pkg::ACT_DOWN)) |=>
		(phase_q == pmsc_pkg::PH_MOVING && count_q == $past(count_q) + 1'b1))
		else $error("corrective move without moving phase or count step");

endmodule

// File: verif/preset_move_settle_controller_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for preset_move_settle_controller_unit: directed and random item beats
// with a beat-level predictor of the phase, direction and action logic.
// Depends on pmsc_pkg and the top level of the block.
module preset_move_settle_controller_unit_tb;

	localparam int HB = pmsc_pkg::HEIGHT_BITS;
	localparam int SB = pmsc_pkg::SIGNED_BITS;
	localparam int CB = pmsc_pkg::CORRECTION_BITS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [pmsc_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 4'd9;

	typedef struct {
		pmsc_pkg::func_t func;
		logic [HB-1:0] goal;
		logic [1:0] dir;
		logic [31:0] tag;
		logic [31:0] now;
		logic signed [SB-1:0] live;
		logic signed [SB-1:0] steady;
	} height_item_t;

	typedef struct {
		pmsc_pkg::action_t act;
		pmsc_pkg::phase_t ph;
		pmsc_pkg::dir_t dir;
	} motion_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [pmsc_pkg::IN_DATA_BITS-1:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [pmsc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [pmsc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [pmsc_pkg::CFG_DATA_BITS-1:0] cfg_data;

	pmsc_pkg::phase_t st_phase;
	pmsc_pkg::dir_t st_dir;
	logic signed [SB-1:0] st_target;
	logic [31:0] st_last_tag;
	logic [31:0] st_settle_start;
	logic [CB-1:0] st_corrections;

	logic [7:0] reg_margin;
	logic [7:0] reg_tolerance;
	logic [15:0] reg_settle_time;
	logic [3:0] reg_max_corr;

	motion_result_t pending_motion_results[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;

	preset_move_settle_controller_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %0s: got %0d, expected %0d (cycle %0d)", what, got, want,
			cycle_count);
		mismatch_count++;
	endtask

	// Handshake signals only change at rising edges, so sampling at the falling
	// edge sees exactly what the next rising edge will act on.
	always @(negedge clk) begin : check_results
		motion_result_t want;
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (pending_motion_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", m_axis_tdata, 0);
			end else begin
				want = pending_motion_results.pop_front();
				if (m_axis_tdata[2:0] !== want.act)
					report_mismatch("action", m_axis_tdata[2:0], want.act);
				if (m_axis_tdata[4:3] !== want.ph)
					report_mismatch("phase_now", m_axis_tdata[4:3], want.ph);
				if (m_axis_tdata[6:5] !== want.dir)
					report_mismatch("dir_now", m_axis_tdata[6:5], want.dir);
			end
		end
	end

	function automatic void clear_motion_state();
		st_phase = pmsc_pkg::PH_IDLE;
		st_dir = pmsc_pkg::DIR_STOP;
		st_target = '1;
		st_last_tag = '0;
		st_settle_start = '0;
		st_corrections = '0;
	endfunction

	function automatic motion_result_t predict_motion_step(input height_item_t it);
		motion_result_t r;
		int live_i, steady_i, target_i, margin_i, err, mag;
		bit reached;
		logic [31:0] elapsed;
		r.act = pmsc_pkg::ACT_NONE;
		case (it.func)
		pmsc_pkg::FUNC_ABORT: begin
			clear_motion_state();
		end
		pmsc_pkg::FUNC_START: begin
			clear_motion_state();
			st_target = {1'b0, it.goal};
			st_dir = (it.dir == 2'd3) ? pmsc_pkg::DIR_STOP : pmsc_pkg::dir_t'(it.dir);
			st_last_tag = it.tag;
			st_phase = pmsc_pkg::PH_MOVING;
		end
		pmsc_pkg::FUNC_SAMPLE: begin
			live_i = it.live;
			steady_i = it.steady;
			target_i = st_target;
			margin_i = reg_margin;
			if (st_phase != pmsc_pkg::PH_IDLE && live_i >= 0 && steady_i >= 0 &&
				it.tag != st_last_tag) begin
				st_last_tag = it.tag;
				if (st_phase == pmsc_pkg::PH_MOVING) begin
					case (st_dir)
					pmsc_pkg::DIR_UP: reached = (live_i >= target_i - margin_i);
					pmsc_pkg::DIR_DOWN: reached = (live_i <= target_i + margin_i);
					default: reached = 1'b1;
					endcase
					if (reached) begin
						st_phase = pmsc_pkg::PH_SETTLING;
						st_dir = pmsc_pkg::DIR_STOP;
						st_settle_start = it.now;
						r.act = pmsc_pkg::ACT_SETTLE;
					end
				end else begin
					elapsed = it.now - st_settle_start;
					if (elapsed >= {16'd0, reg_settle_time}) begin
						err = steady_i - target_i;
						mag = (err < 0) ? -err : err;
						if (mag <= int'(reg_tolerance)) begin
							clear_motion_state();
							r.act = pmsc_pkg::ACT_COMPLETE;
						end else if (st_corrections >= reg_max_corr) begin
							clear_motion_state();
							r.act = pmsc_pkg::ACT_LIMIT;
						end else begin
							st_corrections = st_corrections + 1'b1;
							st_phase = pmsc_pkg::PH_MOVING;
							st_dir = (err < 0) ? pmsc_pkg::DIR_UP : pmsc_pkg::DIR_DOWN;
							r.act = (err < 0) ? pmsc_pkg::ACT_UP : pmsc_pkg::ACT_DOWN;
						end
					end
				end
			end
		end
		default: ;
		endcase
		r.ph = st_phase;
		r.dir = st_dir;
		return r;
	endfunction

	task automatic send_item(input height_item_t it);
		logic [pmsc_pkg::IN_DATA_BITS-1:0] word;
		bit taken;
		while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		word = '0;
		word[pmsc_pkg::GOAL_LSB +: HB] = it.goal;
		word[pmsc_pkg::DIR_LSB +: 2] = it.dir;
		word[pmsc_pkg::TAG_LSB +: 32] = it.tag;
		word[pmsc_pkg::TIME_LSB +: 32] = it.now;
		word[pmsc_pkg::LIVE_LSB +: SB] = it.live;
		word[pmsc_pkg::STEADY_LSB +: SB] = it.steady;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= it.func;
		do begin
			@(negedge clk);
			taken = (s_axis_tready === 1'b1);
			@(posedge clk);
		end while (!taken);
		pending_motion_results.push_back(predict_motion_step(it));
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (pending_motion_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pmsc_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [pmsc_pkg::CFG_DATA_BITS-1:0] value);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(negedge clk);
			taken = (cfg_ready === 1'b1);
			@(posedge clk);
		end while (!taken);
		case (idx)
		pmsc_pkg::REG_STOP_MARGIN: reg_margin = value[7:0];
		pmsc_pkg::REG_SETTLE_TOLERANCE: reg_tolerance = value[7:0];
		pmsc_pkg::REG_SETTLE_TIME: reg_settle_time = value[15:0];
		pmsc_pkg::REG_MAX_CORRECTIONS: reg_max_corr = value[3:0];
		default: ;
		endcase
	endtask

	// Random upper bits go with margin, tolerance and limit; the block drops them.
	task automatic apply_settings(input int margin, input int tolerance, input int settle,
		input int max_corr);
		wait_for_results();
		write_reg(pmsc_pkg::REG_STOP_MARGIN, {8'($urandom), 8'(margin)});
		write_reg(pmsc_pkg::REG_SETTLE_TOLERANCE, {8'($urandom), 8'(tolerance)});
		write_reg(pmsc_pkg::REG_SETTLE_TIME, 16'(settle));
		write_reg(pmsc_pkg::REG_MAX_CORRECTIONS, {12'($urandom), 4'(max_corr)});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic height_item_t make_item(input pmsc_pkg::func_t f, input int goal,
		input int dir, input logic [31:0] tag, input logic [31:0] now, input int live,
		input int steady);
		height_item_t it;
		it.func = f;
		it.goal = goal[HB-1:0];
		it.dir = dir[1:0];
		it.tag = tag;
		it.now = now;
		it.live = live[SB-1:0];
		it.steady = steady[SB-1:0];
		return it;
	endfunction

	function automatic logic signed [SB-1:0] near_height(input int center,
		input int spread);
		int v, off;
		off = $urandom_range(0, 2 * spread);
		v = center + off - spread;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v[SB-1:0];
	endfunction

	// Mostly well-formed move sequences steered by the predicted phase, with
	// some aborts, unused kinds, unknown heights and repeated sample ids mixed in.
	function automatic height_item_t random_motion_item();
		height_item_t it;
		int pick;
		logic [31:0] offset;
		pick = $urandom_range(0, 99);
		it.func = pmsc_pkg::FUNC_SAMPLE;
		it.goal = HB'($urandom);
		it.dir = 2'($urandom);
		it.tag = $urandom;
		if (it.tag == st_last_tag) it.tag = it.tag + 1;
		it.now = $urandom;
		it.live = SB'($urandom_range(0, 4095));
		it.steady = SB'($urandom_range(0, 4095));
		if (pick < 12) begin
			case ($urandom_range(0, 5))
			0: it.func = pmsc_pkg::FUNC_ABORT;
			1: it.func = pmsc_pkg::FUNC_NOP;
			2: begin
				it.live = SB'($urandom);
				it.live[SB-1] = 1'b1;
			end
			3: begin
				it.steady = SB'($urandom);
				it.steady[SB-1] = 1'b1;
			end
			4: it.tag = st_last_tag;
			default: begin
				it.live = SB'($urandom);
				it.steady = SB'($urandom);
			end
			endcase
		end else if (st_phase == pmsc_pkg::PH_IDLE || pick < 17) begin
			it.func = pmsc_pkg::FUNC_START;
		end else if (st_phase == pmsc_pkg::PH_MOVING) begin
			if (pick < 85) it.live = near_height(st_target, int'(reg_margin) + 40);
		end else begin
			if (pick < 40 && reg_settle_time != 0)
				offset = $urandom_range(0, reg_settle_time - 1);
			else
				offset = reg_settle_time + $urandom_range(0, 40);
			if (pick > 95) offset = $urandom;
			it.now = st_settle_start + offset;
			if (pick < 70)
				it.steady = near_height(st_target, int'(reg_tolerance) + 3);
			else
				it.steady = near_height(st_target, int'(reg_tolerance) + 60);
		end
		return it;
	endfunction

	task automatic run_random_items(input int count);
		repeat (count) send_item(random_motion_item());
	endtask

	task automatic test_directed_sequence();
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd3, 32'd0, 100, 100));
		send_item(make_item(pmsc_pkg::FUNC_NOP, 4095, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			4095, 4095));
		send_item(make_item(pmsc_pkg::FUNC_START, 1000, 1, 32'd5, 32'd0, 0, 0));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd5, 32'd0, 1000, 1000));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd6, 32'd0, -1, 1000));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd6, 32'd0, 1000, -4096));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd6, 32'd0, 500, 500));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd7, 32'd100, 990, 990));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd8, 32'd599, 1000, 1000));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd9, 32'd600, 1000, 1020));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd10, 32'hFFFF_FF00,
			1010, 1010));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd11, 32'h0000_00F4,
			980, 980));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd12, 32'd1000, 4095, 4095));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd13, 32'd1500, 0, 0));
		send_item(make_item(pmsc_pkg::FUNC_START, 4095, 3, 32'hFFFF_FFFF, 32'd0, 0, 0));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd1, 32'd0, 0, 0));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd2, 32'd500, 0, 4092));
		send_item(make_item(pmsc_pkg::FUNC_START, 0, 2, 32'd0, 32'd0, 0, 0));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd0, 32'd0, 10, 10));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd3, 32'd77, 10, 10));
		send_item(make_item(pmsc_pkg::FUNC_ABORT, 4095, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			-1, -1));
		send_item(make_item(pmsc_pkg::FUNC_START, 2000, 2, 32'd7, 32'd0, 0, 0));
		send_item(make_item(pmsc_pkg::FUNC_ABORT, 0, 0, 32'd0, 32'd0, 0, 0));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd8, 32'd0, 2000, 2000));
	endtask

	task automatic test_register_extremes();
		apply_settings(0, 0, 0, 0);
		write_reg(REG_UNUSED, 16'hFFFF);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_item(make_item(pmsc_pkg::FUNC_START, 100, 1, 32'd1, 32'd0, 0, 0));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd2, 32'd40, 100, 100));
		send_item(make_item(pmsc_pkg::FUNC_SAMPLE, 0, 0, 32'd3, 32'd40, 100, 101));
		run_random_items(45);
		apply_settings(255, 255, 65535, 15);
		run_random_items(45);
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
			0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
			1: begin sender_idle_pct = 52; recv_stall_pct = 0; end
			2: begin sender_idle_pct = 0; recv_stall_pct = 52; end
			default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			if (p == 0)
				apply_settings(10, 5, 500, 2);
			else if (p == 5)
				apply_settings(255, 0, 65535, 15);
			else
				apply_settings($urandom_range(0, 255), $urandom_range(0, 64),
					($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 2000),
					$urandom_range(0, 15));
			run_random_items(170);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = pmsc_pkg::FUNC_ABORT;
		cfg_valid = 1'b0;
		cfg_index = pmsc_pkg::REG_STOP_MARGIN;
		cfg_data = '0;
		reg_margin = pmsc_pkg::STOP_MARGIN_RESET;
		reg_tolerance = pmsc_pkg::SETTLE_TOLERANCE_RESET;
		reg_settle_time = pmsc_pkg::SETTLE_TIME_RESET;
		reg_max_corr = pmsc_pkg::MAX_CORRECTIONS_RESET;
		clear_motion_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_sequence();
		test_register_extremes();
		test_random_traffic();

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: preset_move_settle_controller_unit.f
design/pmsc_pkg.sv
design/preset_move_settle_controller_unit.sv
verif/preset_move_settle_controller_unit_tb.sv
